@@ src/sprgb_pkg.sv @@
// Package for the spectral-to-RGB converter: colour-matching and D65 matrix
// coefficients, fixed-point widths and shared types.
// No dependencies.
package sprgb_pkg;

	localparam int CHANNEL_COUNT = 10;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int CMF_BITS = 15;     // all colour-matching weights are below 2^15
	localparam int NORM_BITS = 25;    // Q9.16 normalised value
	localparam int MAT_BITS = 27;     // signed, 24 fraction bits
	localparam int NY_BITS = 17;
	localparam int PROD_BITS = MAT_BITS + NORM_BITS + 1;
	localparam int ACC_BITS = PROD_BITS + 2;
	localparam int FRAC_OUT = 40;

	typedef logic [CMF_BITS-1:0] cmf_t;
	typedef logic signed [MAT_BITS-1:0] mat_t;
	typedef logic [7:0] byte_t;

	localparam cmf_t CMF_X [CHANNEL_COUNT] = '{
		15'd380, 15'd1796, 15'd5508, 15'd2328, 15'd152,
		15'd7101, 15'd8076, 15'd17403, 15'd2867, 15'd93};
	localparam cmf_t CMF_Y [CHANNEL_COUNT] = '{
		15'd10, 15'd66, 15'd623, 15'd960, 15'd2774,
		15'd16302, 15'd16384, 15'd10338, 15'd1753, 15'd34};
	localparam cmf_t CMF_Z [CHANNEL_COUNT] = '{
		15'd1806, 15'd8780, 15'd29034, 15'd17215, 15'd3408,
		15'd143, 15'd64, 15'd13, 15'd0, 15'd0};

	// rows red, green, blue; columns x, y, z
	localparam mat_t D65 [3][3] = '{
		'{ 27'sd54368246, -27'sd25789936,  -27'sd8365120},
		'{-27'sd16255445,  27'sd31470702,    27'sd696254},
		'{   27'sd934491,  -27'sd3422552,  27'sd17733517}};

	localparam logic [NY_BITS-1:0] ONE_Q16 = NY_BITS'(65536);

endpackage

@@ src/sprgb_if.sv @@
// Channel interfaces of the spectral-to-RGB converter: spectral frame in,
// RGB pixel out, each with valid/ready. Depends on sprgb_pkg.
interface sprgb_in_if import sprgb_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
	logic valid;
	logic ready;
	logic [SAMPLE_BITS-1:0] chan_405, chan_425, chan_450, chan_475, chan_515;
	logic [SAMPLE_BITS-1:0] chan_550, chan_555, chan_600, chan_640, chan_690;

	modport source (output valid, chan_405, chan_425, chan_450, chan_475, chan_515,
		chan_550, chan_555, chan_600, chan_640, chan_690, input ready);
	modport sink (input valid, chan_405, chan_425, chan_450, chan_475, chan_515,
		chan_550, chan_555, chan_600, chan_640, chan_690, output ready);
endinterface

interface sprgb_out_if import sprgb_pkg::*;;
	logic valid;
	logic ready;
	byte_t red, green, blue;

	modport source (output valid, red, green, blue, input ready);
	modport sink (input valid, red, green, blue, output ready);
endinterface

@@ src/sprgb_div.sv @@
// Pipelined restoring divider, two lanes sharing one divisor: x = X*2^16/Y and
// z = Z*2^16/Y, saturated to Q9.16. One quotient bit per stage. Depends on sprgb_pkg.
module sprgb_div import sprgb_pkg::*; #(
	parameter int W = SAMPLE_BITS_DEF + 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic [W-1:0]         num_x,
	input  logic [W-1:0]         num_z,
	input  logic [W-1:0]         den,
	output logic                 out_valid,
	output logic [NORM_BITS-1:0] quot_x,
	output logic [NORM_BITS-1:0] quot_z,
	output logic                 den_zero
);
	localparam int QB = NORM_BITS;
	localparam int RW = W + QB;

	logic          v_q   [0:QB];
	logic [RW-1:0] rx_q  [0:QB];
	logic [RW-1:0] rz_q  [0:QB];
	logic [QB-1:0] qx_q  [0:QB];
	logic [QB-1:0] qz_q  [0:QB];
	logic [W-1:0]  den_q [0:QB-1];
	logic          ovx_q [0:QB];
	logic          ovz_q [0:QB];
	logic          zero_q[0:QB];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= QB; k++) v_q[k] <= 1'b0;
		end else if (en) begin
			v_q[0] <= in_valid;
			for (int k = 0; k < QB; k++) v_q[k+1] <= v_q[k];
		end
	end

	// quotient reaches 2^25 exactly when X >= Y*2^9
	always_ff @(posedge clk) begin
		if (en) begin
			rx_q[0]   <= RW'(num_x) << 16;
			rz_q[0]   <= RW'(num_z) << 16;
			ovx_q[0]  <= (RW'(num_x) << 16) >= (RW'(den) << 25);
			ovz_q[0]  <= (RW'(num_z) << 16) >= (RW'(den) << 25);
			qx_q[0]   <= '0;
			qz_q[0]   <= '0;
			den_q[0]  <= den;
			zero_q[0] <= (den == '0);
		end
	end

	for (genvar k = 0; k < QB; k++) begin : g_step
		logic [RW-1:0] dsh;
		assign dsh = RW'(den_q[k]) << (QB - 1 - k);
		always_ff @(posedge clk) begin
			if (en) begin
				if (rx_q[k] >= dsh) begin
					rx_q[k+1] <= rx_q[k] - dsh;
					qx_q[k+1] <= {qx_q[k][QB-2:0], 1'b1};
				end else begin
					rx_q[k+1] <= rx_q[k];
					qx_q[k+1] <= {qx_q[k][QB-2:0], 1'b0};
				end
				if (rz_q[k] >= dsh) begin
					rz_q[k+1] <= rz_q[k] - dsh;
					qz_q[k+1] <= {qz_q[k][QB-2:0], 1'b1};
				end else begin
					rz_q[k+1] <= rz_q[k];
					qz_q[k+1] <= {qz_q[k][QB-2:0], 1'b0};
				end
				ovx_q[k+1]  <= ovx_q[k];
				ovz_q[k+1]  <= ovz_q[k];
				zero_q[k+1] <= zero_q[k];
			end
		end
		if (k < QB - 1) begin : g_den
			always_ff @(posedge clk) begin
				if (en) begin
					den_q[k+1] <= den_q[k];
				end
			end
		end
	end

	// Y is zero only for an all-zero frame, where X and Z are zero as well
	always_comb begin
		out_valid = v_q[QB];
		den_zero  = zero_q[QB];
		if (zero_q[QB]) begin
			quot_x = '0;
			quot_z = '0;
		end else begin
			quot_x = ovx_q[QB] ? '1 : qx_q[QB];
			quot_z = ovz_q[QB] ? '1 : qz_q[QB];
		end
	end
endmodule

@@ src/spectral_to_rgb_converter_top.sv @@
// Spectral-to-RGB converter: ten channel counts -> XYZ -> normalised -> linear RGB.
// Pipeline: 3 MAC stages, 26 divider stages and 3 matrix stages, the last being the
// output register. Throughput: one frame per cycle while the output is not stalled;
// the 25-stage quotient pipeline sets the depth. A stall at the output holds
// all stages. Reset clears the valid bits only; payload registers are not reset.
module spectral_to_rgb_converter_top import sprgb_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input logic      clk,
	input logic      arst_n,
	sprgb_in_if.sink  in_ch,
	sprgb_out_if.source out_px
);
	localparam int PB = SAMPLE_BITS + CMF_BITS;
	localparam int W = SAMPLE_BITS + 16;

	logic en;
	logic [SAMPLE_BITS-1:0] smp [CHANNEL_COUNT];

	assign smp[0] = in_ch.chan_405;
	assign smp[1] = in_ch.chan_425;
	assign smp[2] = in_ch.chan_450;
	assign smp[3] = in_ch.chan_475;
	assign smp[4] = in_ch.chan_515;
	assign smp[5] = in_ch.chan_550;
	assign smp[6] = in_ch.chan_555;
	assign smp[7] = in_ch.chan_600;
	assign smp[8] = in_ch.chan_640;
	assign smp[9] = in_ch.chan_690;

	logic v_s1, v_s2, v_s3, v_m1, v_m2, v_m3;
	logic [PB-1:0] px_s1 [CHANNEL_COUNT];
	logic [PB-1:0] py_s1 [CHANNEL_COUNT];
	logic [PB-1:0] pz_s1 [CHANNEL_COUNT];
	logic [W-1:0]  hx_s2 [2];
	logic [W-1:0]  hy_s2 [2];
	logic [W-1:0]  hz_s2 [2];
	logic [W-1:0]  sx_s3, sy_s3, sz_s3;

	logic                 dv;
	logic [NORM_BITS-1:0] nx, nz;
	logic                 yzero;
	logic [NY_BITS-1:0]   ny;

	logic signed [PROD_BITS-1:0] p_m1 [3][3];
	logic signed [ACC_BITS-1:0]  acc_m2 [3];
	logic [FRAC_OUT+7:0]         scl [3];
	byte_t                       rgb_m3 [3];

	assign en = !v_m3 || out_px.ready;
	assign in_ch.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_m1 <= 1'b0;
			v_m2 <= 1'b0;
			v_m3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_ch.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_m1 <= dv;
			v_m2 <= v_m1;
			v_m3 <= v_m2;
		end
	end

	// weighting, two half sums, full sums
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < CHANNEL_COUNT; i++) begin
				px_s1[i] <= PB'(smp[i]) * PB'(CMF_X[i]);
				py_s1[i] <= PB'(smp[i]) * PB'(CMF_Y[i]);
				pz_s1[i] <= PB'(smp[i]) * PB'(CMF_Z[i]);
			end
			for (int h = 0; h < 2; h++) begin
				hx_s2[h] <= W'(px_s1[5*h]) + W'(px_s1[5*h+1]) + W'(px_s1[5*h+2])
					+ W'(px_s1[5*h+3]) + W'(px_s1[5*h+4]);
				hy_s2[h] <= W'(py_s1[5*h]) + W'(py_s1[5*h+1]) + W'(py_s1[5*h+2])
					+ W'(py_s1[5*h+3]) + W'(py_s1[5*h+4]);
				hz_s2[h] <= W'(pz_s1[5*h]) + W'(pz_s1[5*h+1]) + W'(pz_s1[5*h+2])
					+ W'(pz_s1[5*h+3]) + W'(pz_s1[5*h+4]);
			end
			sx_s3 <= hx_s2[0] + hx_s2[1];
			sy_s3 <= hy_s2[0] + hy_s2[1];
			sz_s3 <= hz_s2[0] + hz_s2[1];
		end
	end

	sprgb_div #(.W(W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s3),
		.num_x    (sx_s3),
		.num_z    (sz_s3),
		.den      (sy_s3),
		.out_valid(dv),
		.quot_x   (nx),
		.quot_z   (nz),
		.den_zero (yzero)
	);

	assign ny = yzero ? '0 : ONE_Q16;

	// 255 * fraction, top byte taken below
	always_comb begin
		for (int r = 0; r < 3; r++)
			scl[r] = ({8'd0, acc_m2[r][FRAC_OUT-1:0]} << 8) - {8'd0, acc_m2[r][FRAC_OUT-1:0]};
	end

	// matrix: products, row sums, clamp and scale by 255
	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				p_m1[r][0] <= PROD_BITS'($signed({1'b0, nx})) * PROD_BITS'(D65[r][0]);
				p_m1[r][1] <= PROD_BITS'($signed({1'b0, ny})) * PROD_BITS'(D65[r][1]);
				p_m1[r][2] <= PROD_BITS'($signed({1'b0, nz})) * PROD_BITS'(D65[r][2]);
				acc_m2[r] <= ACC_BITS'(p_m1[r][0]) + ACC_BITS'(p_m1[r][1])
					+ ACC_BITS'(p_m1[r][2]);
			end
			for (int r = 0; r < 3; r++) begin
				if (acc_m2[r] <= 0)
					rgb_m3[r] <= 8'd0;
				else if (acc_m2[r] >= (ACC_BITS'(1) <<< FRAC_OUT))
					rgb_m3[r] <= 8'd255;
				else
					rgb_m3[r] <= scl[r][FRAC_OUT+7:FRAC_OUT];
			end
		end
	end

	assign out_px.valid = v_m3;
	assign out_px.red   = rgb_m3[0];
	assign out_px.green = rgb_m3[1];
	assign out_px.blue  = rgb_m3[2];
endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// Testbench for spectral_to_rgb_converter_top: random spectral frames in, RGB pixels out,
// each pixel checked against a predictor of the XYZ -> normalise -> D65 matrix path.
// Depends on sprgb_pkg and sprgb_if.
module tb;
	import sprgb_pkg::*;

	typedef struct {
		logic [15:0] ch [CHANNEL_COUNT];
	} frame_t;

	typedef struct {
		byte_t red, green, blue;
	} pixel_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   n_err = 0;
	bit   stim_done = 1'b0;

	frame_t frame_q [$];
	pixel_t pixel_q [$];
	frame_t cur_frame;

	sprgb_in_if #(.SAMPLE_BITS(16)) in_ch ();
	sprgb_out_if out_px ();

	spectral_to_rgb_converter_top #(.SAMPLE_BITS(16)) i_dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_px(out_px.source)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic byte_t clamp_byte(logic signed [79:0] acc);
		logic signed [79:0] one;
		logic [79:0] scaled;
		one = 80'sd1 <<< 40;
		if (acc <= 0)
			return 8'd0;
		if (acc >= one)
			return 8'd255;
		scaled = ($unsigned(acc) * 80'd255) >> 40;
		return scaled[7:0];
	endfunction

	function automatic pixel_t frame_to_pixel(frame_t f);
		logic [63:0] sx, sy, sz, nx, ny, nz, lim;
		logic signed [79:0] acc [3];
		byte_t res [3];
		pixel_t p;
		sx = 0; sy = 0; sz = 0;
		lim = (64'd1 << NORM_BITS) - 1;
		for (int i = 0; i < CHANNEL_COUNT; i++) begin
			sx += 64'(f.ch[i]) * 64'(CMF_X[i]);
			sy += 64'(f.ch[i]) * 64'(CMF_Y[i]);
			sz += 64'(f.ch[i]) * 64'(CMF_Z[i]);
		end
		if (sy != 0) begin
			nx = (sx << 16) / sy;
			nz = (sz << 16) / sy;
			ny = 64'd65536;
		end else begin
			nx = sx << 2;
			nz = sz << 2;
			ny = 0;
		end
		if (nx > lim) nx = lim;
		if (nz > lim) nz = lim;
		for (int r = 0; r < 3; r++) begin
			acc[r] = 80'(D65[r][0]) * $signed({1'b0, nx}) + 80'(D65[r][1]) * $signed({1'b0, ny})
				+ 80'(D65[r][2]) * $signed({1'b0, nz});
			res[r] = clamp_byte(acc[r]);
		end
		p.red = res[0]; p.green = res[1]; p.blue = res[2];
		return p;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		n_err++;
	endtask

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [15:0] rand_sample(int mode);
		case (mode)
			0: return 16'($urandom);
			1: return 16'($urandom_range(0, 255));
			2: return 16'($urandom_range(0, 1)) ? 16'hFFFF : 16'h0000;
			default: return 16'(1 << $urandom_range(0, 15));
		endcase
	endfunction

	// stimulus: directed extremes, then random frames with varied sparsity
	initial begin
		frame_t f;
		int mode;
		for (int i = 0; i < CHANNEL_COUNT; i++) f.ch[i] = 16'h0000;
		frame_q.push_back(f);                    // zero luminance
		for (int i = 0; i < CHANNEL_COUNT; i++) f.ch[i] = 16'hFFFF;
		frame_q.push_back(f);
		for (int k = 0; k < CHANNEL_COUNT; k++) begin
			for (int i = 0; i < CHANNEL_COUNT; i++) f.ch[i] = (i == k) ? 16'hFFFF : 16'h0000;
			frame_q.push_back(f);
			for (int i = 0; i < CHANNEL_COUNT; i++) f.ch[i] = (i == k) ? 16'h0001 : 16'h0000;
			frame_q.push_back(f);
		end
		for (int i = 0; i < CHANNEL_COUNT; i++) f.ch[i] = 16'h5555 << (i & 1);
		frame_q.push_back(f);
		for (int n = 0; n < 1800; n++) begin
			mode = $urandom_range(0, 3);
			for (int i = 0; i < CHANNEL_COUNT; i++)
				f.ch[i] = ($urandom_range(0, 4) == 0) ? 16'h0000 : rand_sample(mode);
			frame_q.push_back(f);
		end
		stim_done = 1'b1;
	end

	// driver
	int in_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
		end else begin
			if (!in_ch.valid || in_ch.ready) begin
				if (in_ch.valid) pixel_q.push_back(frame_to_pixel(cur_frame));
				if (in_gap > 0 || frame_q.size() == 0) begin
					if (in_gap > 0) in_gap <= in_gap - 1;
					in_ch.valid <= 1'b0;
				end else begin
					cur_frame = frame_q.pop_front();
					in_ch.valid <= 1'b1;
					in_ch.chan_405 <= cur_frame.ch[0];
					in_ch.chan_425 <= cur_frame.ch[1];
					in_ch.chan_450 <= cur_frame.ch[2];
					in_ch.chan_475 <= cur_frame.ch[3];
					in_ch.chan_515 <= cur_frame.ch[4];
					in_ch.chan_550 <= cur_frame.ch[5];
					in_ch.chan_555 <= cur_frame.ch[6];
					in_ch.chan_600 <= cur_frame.ch[7];
					in_ch.chan_640 <= cur_frame.ch[8];
					in_ch.chan_690 <= cur_frame.ch[9];
					in_gap <= gap_len();
				end
			end
		end
	end

	initial begin
		in_ch.valid = 1'b0;
		{in_ch.chan_405, in_ch.chan_425, in_ch.chan_450, in_ch.chan_475, in_ch.chan_515} = '0;
		{in_ch.chan_550, in_ch.chan_555, in_ch.chan_600, in_ch.chan_640, in_ch.chan_690} = '0;
		out_px.ready = 1'b0;
	end

	// monitor; ready toggles with random stalls
	int out_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		pixel_t want;
		if (!arst_n) begin
			out_px.ready <= 1'b0;
		end else begin
			if (out_px.valid && out_px.ready) begin
				if (pixel_q.size() == 0) begin
					report_mismatch("unexpected pixel", 1, 0);
				end else begin
					want = pixel_q.pop_front();
					if (out_px.red !== want.red) report_mismatch("red", out_px.red, want.red);
					if (out_px.green !== want.green)
						report_mismatch("green", out_px.green, want.green);
					if (out_px.blue !== want.blue) report_mismatch("blue", out_px.blue, want.blue);
				end
			end
			if (out_gap > 0) begin
				out_gap <= out_gap - 1;
				out_px.ready <= 1'b0;
			end else begin
				out_px.ready <= 1'b1;
				out_gap <= gap_len();
			end
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		wait (stim_done && frame_q.size() == 0);
		@(posedge clk);
		while (in_ch.valid || pixel_q.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (n_err == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#10ms;
		$display("== FAIL ==");
		$finish;
	end
endmodule
